>>> sv/lfsm_pkg.sv
// shared constants and types for the line fixed-string matcher
package lfsm_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int LEN_W             = 5;
    localparam int CFG_W             = 64;
    localparam int ADDR_W            = 5;
    localparam int LINE_W            = 32;
    localparam int COUNT_W           = 16;
    localparam int IN_DATA_W         = 8;
    localparam int OUT_DATA_W        = LINE_W + COUNT_W;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0a;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [1:0] REG_PATTERN_HIGH   = 2'd2;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] t_byte_window;

    typedef struct packed {
        logic [COUNT_W-1:0] occurrence_count;
        logic [LINE_W-1:0]  line_index;
    } t_out_word;

endpackage

>>> sv/line_fixed_string_matcher.sv
// line fixed-string matcher: per-line pattern occurrence counter on a byte stream
//
//  channel  dir  handshake        contents
//  s        in   tvalid/tready    tdata = text_byte, tlast = end_of_text
//  m        out  tvalid/tready    tdata = line_index, occurrence_count; tuser = line_matched
//  apb      in   psel/penable     pattern_length @0, pattern_bytes_low @8, pattern_bytes_high @16
//
// one word per cycle unless the output stalls; line results go from input to output register
// the input register feeds a single pass of 16 parallel byte compares and the line counters
// a word that closes a line waits in the input register only while the output word is stalled
// i_rst_n is synchronous: clears the counters, the valid flags and the configuration
module line_fixed_string_matcher
    import lfsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [7:0] text_byte
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [31:0] line_index, [47:32] occurrence_count
    output logic                  o_m_tuser,   // [0] line_matched
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [CFG_W-1:0]      pwdata,
    output logic [CFG_W-1:0]      prdata,
    output logic                  pready
);

    localparam logic [LEN_W-1:0]   MAX_LEN   = LEN_W'(MAX_PATTERN_BYTES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [LINE_W-1:0]  LINE_MAX  = '1;

    // configuration
    logic [LEN_W-1:0] r_pat_len;
    logic [CFG_W-1:0] r_pat_low;
    logic [CFG_W-1:0] r_pat_high;

    // input register
    logic                 r_s1_valid;
    logic [7:0]           r_s1_byte;
    logic                 r_s1_last;

    // line state
    t_byte_window         r_win;
    logic [LEN_W-1:0]     r_bytes_in_line;
    logic [COUNT_W-1:0]   r_occ;
    logic [LINE_W-1:0]    r_line;

    // output register
    logic                 r_out_valid;
    t_out_word            r_out_word;
    logic                 r_out_matched;

    logic                 cfg_write;
    logic [1:0]           cfg_index;
    t_byte_window         pat_bytes;
    t_byte_window         n_win;
    logic [LEN_W-1:0]     n_bytes_in_line;
    logic [LEN_W-1:0]     eff_len;
    logic [LEN_W-1:0]     pat_idx;
    logic                 window_hit;
    logic                 end_of_line;
    logic [COUNT_W-1:0]   n_occ;
    logic                 s1_fire;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len  <= '0;
            r_pat_low  <= '0;
            r_pat_high <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_PATTERN_LENGTH: r_pat_len  <= pwdata[LEN_W-1:0];
                REG_PATTERN_LOW:    r_pat_low  <= pwdata;
                REG_PATTERN_HIGH:   r_pat_high <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_PATTERN_LENGTH: prdata = {{(CFG_W-LEN_W){1'b0}}, r_pat_len};
            REG_PATTERN_LOW:    prdata = r_pat_low;
            REG_PATTERN_HIGH:   prdata = r_pat_high;
            default:            prdata = '0;
        endcase
    end

    assign pat_bytes = {r_pat_high, r_pat_low};

    // match logic on the word in the input register
    always_comb begin
        n_win = {r_win[MAX_PATTERN_BYTES-2:0], r_s1_byte};
        n_bytes_in_line = (r_bytes_in_line >= MAX_LEN) ? MAX_LEN : r_bytes_in_line + 1'b1;
        eff_len = (r_pat_len > MAX_LEN) ? MAX_LEN : r_pat_len;
        window_hit = (eff_len != '0) && (n_bytes_in_line >= eff_len);
        pat_idx = '0;
        // newest byte lines up with the last pattern byte
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            pat_idx = eff_len - 1'b1 - LEN_W'(j);
            if ((LEN_W'(j) < eff_len) && (n_win[j] != pat_bytes[pat_idx[3:0]])) begin
                window_hit = 1'b0;
            end
        end
        n_occ = (window_hit && (r_occ != COUNT_MAX)) ? r_occ + 1'b1 : r_occ;
        end_of_line = (r_s1_byte == NEWLINE_BYTE) || r_s1_last;
    end

    assign s1_fire    = r_s1_valid && (!end_of_line || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_byte <= i_s_tdata;
            r_s1_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_line <= '0;
            r_occ           <= '0;
            r_line          <= '0;
        end else if (s1_fire) begin
            if (end_of_line) begin
                r_bytes_in_line <= '0;
                r_occ           <= '0;
                if (r_s1_last) begin
                    r_line <= '0;
                end else if (r_line != LINE_MAX) begin
                    r_line <= r_line + 1'b1;
                end
            end else begin
                r_bytes_in_line <= n_bytes_in_line;
                r_occ           <= n_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && end_of_line) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && end_of_line) begin
            r_out_word.line_index       <= r_line;
            r_out_word.occurrence_count <= n_occ;
            r_out_matched               <= (n_occ != '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_word;
    assign o_m_tuser  = r_out_matched;

`ifndef SYNTH
    a_bytes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_in_line <= MAX_LEN)
        else $error("line byte count above pattern capacity");

    a_matched_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_matched == (r_out_word.occurrence_count != '0)))
        else $error("matched flag disagrees with occurrence count");

    a_text_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_last) |=> (r_line == '0) && (r_occ == '0) && r_out_valid)
        else $error("end of text did not close the line and restart numbering");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> r_out_valid && $stable(r_out_word))
        else $error("pending result overwritten");
`endif

endmodule

>>> dv/lfsm_checker.sv
`timescale 1ns / 100ps
// line result predictor and output word checker for the line fixed-string matcher
module lfsm_checker
    import lfsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tlast,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tuser,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [ADDR_W-1:0]     i_paddr,
    input  logic [CFG_W-1:0]      i_pwdata,
    input  logic                  i_pready,
    output int                    o_failures,
    output int                    o_pending
);

    typedef struct packed {
        logic [LINE_W-1:0]  line_no;
        logic               matched;
        logic [COUNT_W-1:0] hits;
    } t_line_result;

    t_line_result lines_due[$];

    // configuration copy
    logic [LEN_W-1:0] pat_len;
    t_byte_window     pat_bytes;

    // line scan state, entry 0 of the window is the newest byte
    t_byte_window       window;
    logic [LEN_W-1:0]   line_fill;
    logic [COUNT_W-1:0] line_hits;
    logic [LINE_W-1:0]  line_number;

    always @(posedge i_clk) begin : scan
        t_line_result want;
        t_out_word    got;
        int           eff_len;
        int           k;
        logic         hit;

        if (!i_rst_n) begin
            pat_len     = '0;
            pat_bytes   = '0;
            window      = '0;
            line_fill   = '0;
            line_hits   = '0;
            line_number = '0;
            o_failures  = 0;
            lines_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                window = {window[MAX_PATTERN_BYTES-2:0], i_s_tdata};
                if (line_fill < MAX_PATTERN_BYTES)
                    line_fill = line_fill + 1'b1;
                eff_len = (pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len);
                hit = (eff_len != 0) && (int'(line_fill) >= eff_len);
                for (k = 0; k < eff_len; k++) begin
                    if (window[eff_len-1-k] != pat_bytes[k])
                        hit = 1'b0;
                end
                if (hit && line_hits != '1)
                    line_hits = line_hits + 1'b1;
                if (i_s_tdata == NEWLINE_BYTE || i_s_tlast) begin
                    want.line_no = line_number;
                    want.matched = (line_hits != '0);
                    want.hits    = line_hits;
                    lines_due.push_back(want);
                    line_hits = '0;
                    line_fill = '0;
                    if (i_s_tlast)
                        line_number = '0;
                    else if (line_number != '1)
                        line_number = line_number + 1'b1;
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                got = t_out_word'(i_m_tdata);
                if (lines_due.size() == 0) begin
                    $error("unexpected word: line_index %0d occurrence_count %0d line_matched %0b",
                           got.line_index, got.occurrence_count, i_m_tuser);
                    o_failures++;
                end else begin
                    want = lines_due.pop_front();
                    if (got.line_index !== want.line_no) begin
                        $error("line_index: expected %0d, got %0d", want.line_no, got.line_index);
                        o_failures++;
                    end
                    if (i_m_tuser !== want.matched) begin
                        $error("line_matched: expected %0b, got %0b", want.matched, i_m_tuser);
                        o_failures++;
                    end
                    if (got.occurrence_count !== want.hits) begin
                        $error("occurrence_count: expected %0d, got %0d",
                               want.hits, got.occurrence_count);
                        o_failures++;
                    end
                end
            end

            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    REG_PATTERN_LENGTH: pat_len = i_pwdata[LEN_W-1:0];
                    REG_PATTERN_LOW:    pat_bytes[7:0] = i_pwdata;
                    REG_PATTERN_HIGH:   pat_bytes[15:8] = i_pwdata;
                    default: ;
                endcase
            end
        end
        o_pending = lines_due.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// testbench top for the line fixed-string matcher: clock, reset, stimulus and verdict
module tb;
    import lfsm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 240;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [CFG_W-1:0]      pwdata;
    logic [CFG_W-1:0]      prdata;
    logic                  pready;

    int send_idle_pct;
    int recv_stall_pct;
    int failures;
    int lines_pending;
    int quiet_cycles = 0;

    // pattern currently loaded, used to steer the text toward matches
    t_byte_window cur_pattern;
    int           cur_len;

    line_fixed_string_matcher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    lfsm_checker line_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_failures (failures),
        .o_pending  (lines_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles without any accepted word
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [7:0] text, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // hold the stream until every line result is out, then let the pipeline drain
    task automatic quiesce();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (lines_pending != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_pattern(input int len_field, input t_byte_window pat);
        logic [CFG_W-1:0] len_word;
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len_field[LEN_W-1:0];
        apb_write(REG_PATTERN_LENGTH, len_word);
        apb_write(REG_PATTERN_LOW, pat[7:0]);
        apb_write(REG_PATTERN_HIGH, pat[15:8]);
        cur_pattern = pat;
        cur_len     = (len_field > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : len_field;
    endtask

    // text built mostly from planted pattern copies and pattern bytes, with newlines
    task automatic run_text(input int n_words);
        int sent;
        int r;
        int k;
        int plant;
        sent = 0;
        while (sent < n_words) begin
            r = $urandom_range(99);
            if (r < 30 && cur_len > 0) begin
                // now and then a truncated copy
                plant = ($urandom_range(4) == 0) ? $urandom_range(cur_len - 1) : cur_len;
                for (k = 0; k < plant; k++)
                    send_word(cur_pattern[k], 1'b0);
                sent += plant;
            end else if (r < 40) begin
                send_word(NEWLINE_BYTE, 1'b0);
                sent++;
            end else if (r < 42) begin
                send_word(8'($urandom_range(255)), 1'b1);
                sent++;
            end else if (r < 75 && cur_len > 0) begin
                send_word(cur_pattern[$urandom_range(cur_len - 1)], 1'b0);
                sent++;
            end else begin
                send_word(8'($urandom_range(255)), $urandom_range(199) == 0);
                sent++;
            end
        end
    endtask

    initial begin
        t_byte_window pb;
        int           len;
        int           ph;
        int           k;
        logic [7:0]   fill;

        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_pattern    = '0;
        cur_len        = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero length after reset: lines close but nothing matches
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(NEWLINE_BYTE, 1'b0);
        send_word(8'h78, 1'b1);

        // all-zero pattern, overlapping hits, then newline together with end of text
        quiesce();
        load_pattern(2, '0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(NEWLINE_BYTE, 1'b0);
        send_word(NEWLINE_BYTE, 1'b1);

        // oversized length clamps to 16, pattern ends in a newline
        quiesce();
        for (k = 0; k < MAX_PATTERN_BYTES; k++)
            pb[k] = 8'($urandom_range(255));
        pb[MAX_PATTERN_BYTES-1] = NEWLINE_BYTE;
        load_pattern(31, pb);
        for (k = 0; k < MAX_PATTERN_BYTES; k++)
            send_word(pb[k], 1'b0);

        // random phases; lines stay open across the config changes
        for (ph = 0; ph < 8; ph++) begin
            for (k = 0; k < MAX_PATTERN_BYTES; k++)
                pb[k] = 8'($urandom_range(255));
            case (ph)
                0: len = 1;
                1: begin
                    len = MAX_PATTERN_BYTES;
                    for (k = 0; k < MAX_PATTERN_BYTES; k++)
                        pb[k] = 8'h61 + 8'($urandom_range(2));
                end
                2: begin
                    len  = $urandom_range(2, 6);
                    fill = 8'($urandom_range(255));
                    for (k = 0; k < MAX_PATTERN_BYTES; k++)
                        pb[k] = fill;
                end
                3: begin
                    len = $urandom_range(1, MAX_PATTERN_BYTES);
                    pb[len-1] = NEWLINE_BYTE;
                end
                4: len = 0;
                5: len = $urandom_range(MAX_PATTERN_BYTES + 1, 31);
                6: begin
                    len = $urandom_range(1, MAX_PATTERN_BYTES);
                    for (k = 0; k < MAX_PATTERN_BYTES; k++)
                        pb[k] = $urandom_range(1) ? 8'hff : 8'h00;
                end
                default: len = $urandom_range(0, 31);
            endcase
            quiesce();
            load_pattern(len, pb);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            run_text(PHASE_WORDS);
        end

        quiesce();
        if (failures == 0 && lines_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/lfsm_pkg.sv
sv/line_fixed_string_matcher.sv
dv/lfsm_checker.sv
dv/tb.sv
